### rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes of the sorted priority queue
// Entry, request, response and cell control types, status and mode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

   // default depth of the queue
   localparam int CAPACITY_DEFAULT = 16;

   localparam int VALUE_W  = 32;
   localparam int KEY_W    = 16;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 5;

   // request modes
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_POP    = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // one request word
   typedef struct packed {
      logic                      mode;
      logic signed [VALUE_W-1:0] item_value;
      logic        [KEY_W-1:0]   item_priority;
   } spq_req_type;

   // one response word
   typedef struct packed {
      logic signed [VALUE_W-1:0] out_value;
      logic        [KEY_W-1:0]   out_priority;
      logic        [STATUS_W-1:0] status;
      logic        [FILL_W-1:0]  fill_count;
   } spq_rsp_type;

   // one stored entry
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic        [KEY_W-1:0]   key;
   } spq_entry_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic          shift_in;   // insert: open a gap and fill it
      logic          shift_out;  // pop: move every entry one cell down
      spq_entry_type new_entry;
   } spq_ctrl_type;

endpackage : spq_pkg

`default_nettype wire

### rtl/core/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue held as a sorted cell chain
// Insert places an entry behind all entries of lower or equal key; pop
// returns the entry of lowest key.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_data and raise start; the word is taken at a
//   rising edge with start high and busy low. busy is high only while reset
//   is asserted, so one request is taken every cycle otherwise.
//   Response channel: exactly one response word per request, shown on
//   rsp_data for one cycle with rsp_strobe high, in the cycle after the
//   request is taken. Throughput 1 request per cycle.
//   All cells compare their key with the incoming one in parallel and shift
//   by one place in the same cycle, so the throughput holds at any CAPACITY.
//   The receiver cannot stall; every response must be captured when shown.
//   Status reports a done item, an insert dropped on a full queue or a pop
//   of an empty queue; fill_count is the entry count after the item, kept
//   to its low five bits.
//   Reset (synchronous) empties the queue and drops any pending response;
//   no clearing pass is needed since slots above the fill count are unused.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire spq_pkg::spq_req_type req_data,
   output logic                     rsp_strobe,
   output spq_pkg::spq_rsp_type     rsp_data
);
   import spq_pkg::*;

   localparam int COUNT_W = $clog2(CAPACITY + 1);

   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;
   logic                rsp_strobe_ff;
   spq_rsp_type         rsp_data_ff;
   spq_rsp_type         rsp_data_in;
   logic                accept;
   logic                is_full;
   logic                is_empty;
   logic                do_insert;
   logic                do_pop;
   spq_ctrl_type        ctrl;
   logic [COUNT_W+FILL_W-1:0] count_ext;

   logic          greater [CAPACITY];
   spq_entry_type entries [CAPACITY];

   // hold requests off while reset is applied
   assign busy     = reset;
   assign accept   = start && !busy;
   assign is_full  = count_ff == COUNT_W'(CAPACITY);
   assign is_empty = count_ff == '0;
   assign do_insert = accept && (req_data.mode == MODE_INSERT) && !is_full;
   assign do_pop    = accept && (req_data.mode == MODE_POP) && !is_empty;

   // broadcast to the chain
   assign ctrl.shift_in        = do_insert;
   assign ctrl.shift_out       = do_pop;
   assign ctrl.new_entry.value = req_data.item_value;
   assign ctrl.new_entry.key   = req_data.item_priority;

   // the chain of cells, slot 0 holds the lowest key
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic          left_greater;
      spq_entry_type left_entry;
      spq_entry_type right_entry;

      if (i == 0) begin : g_first
         assign left_greater = 1'b0;
         assign left_entry   = '0;
      end else begin : g_inner
         assign left_greater = greater[i-1];
         assign left_entry   = entries[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_body
         assign right_entry = entries[i+1];
      end

      spq_cell #(
         .INDEX   (i),
         .COUNT_W (COUNT_W)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .held_count   (count_ff),
         .left_greater (left_greater),
         .left_entry   (left_entry),
         .right_entry  (right_entry),
         .greater      (greater[i]),
         .entry        (entries[i])
      );
   end

   // advance the fill count
   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_pop) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   assign count_ext = {{FILL_W{1'b0}}, count_in};

   // build the response word
   always_comb begin
      rsp_data_in.out_value    = '0;
      rsp_data_in.out_priority = '0;
      rsp_data_in.status       = STATUS_DONE;
      rsp_data_in.fill_count   = count_ext[FILL_W-1:0];
      if (req_data.mode == MODE_INSERT) begin
         if (is_full) begin
            rsp_data_in.status = STATUS_FULL;
         end
      end else if (is_empty) begin
         rsp_data_in.status = STATUS_EMPTY;
      end else begin
         rsp_data_in.out_value    = entries[0].value;
         rsp_data_in.out_priority = entries[0].key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
   end

   // hold the response payload until the next request is taken
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule : sorted_priority_queue

`default_nettype wire

### rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted priority queue chain
// Holds one entry, compares it with the key being inserted and takes its
// neighbour's entry, the new entry or its own according to the broadcast.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell #(
   parameter int INDEX   = 0,
   parameter int COUNT_W = 5
) (
   input  wire logic                  clock,
   input  wire spq_pkg::spq_ctrl_type ctrl,
   input  wire logic [COUNT_W-1:0]    held_count,
   input  wire logic                  left_greater,
   input  wire spq_pkg::spq_entry_type left_entry,
   input  wire spq_pkg::spq_entry_type right_entry,
   output logic                       greater,
   output spq_pkg::spq_entry_type     entry
);
   import spq_pkg::*;

   spq_entry_type entry_ff;
   spq_entry_type entry_in;
   logic          valid;

   // slot is occupied when it lies below the fill count
   assign valid   = held_count > COUNT_W'(INDEX);
   // empty slots count as holding a larger key
   assign greater = !valid || (entry_ff.key > ctrl.new_entry.key);
   assign entry   = entry_ff;

   // choose the next entry of this slot
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift_in) begin
         if (left_greater) begin
            entry_in = left_entry;
         end else if (greater) begin
            entry_in = ctrl.new_entry;
         end
      end else if (ctrl.shift_out) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule : spq_cell

`default_nettype wire

### rtl/core/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker: port level checks of the sorted priority queue
// Watches the request and response ports and flags words that break the
// one-request-one-response rule or carry inconsistent status.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_checker #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire logic                 busy,
   input wire spq_pkg::spq_req_type req_data,
   input wire logic                 rsp_strobe,
   input wire spq_pkg::spq_rsp_type rsp_data
);
   import spq_pkg::*;

   localparam int CAP_EXT_W = $clog2(CAPACITY + 1) + FILL_W;
   localparam logic [CAP_EXT_W-1:0] CAP_EXT = CAP_EXT_W'(CAPACITY);

   // every taken request gives a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("request taken without a response");

   // no response without a request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("response without a request");

   // a pop on empty reports an empty queue and no data
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status == STATUS_EMPTY)) |->
         (rsp_data.fill_count == '0) && (rsp_data.out_value == '0)
         && ($past(req_data.mode) == MODE_POP))
      else $error("empty status with data or nonzero fill");

   // a dropped insert reports a full queue
   a_full_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status == STATUS_FULL)) |->
         (rsp_data.fill_count == CAP_EXT[FILL_W-1:0])
         && ($past(req_data.mode) == MODE_INSERT))
      else $error("full status with wrong fill count");

endmodule : spq_checker

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);

`default_nettype wire
